// ===== design/tba_pkg.sv =====
// Shared types and constants for the time-binned averager.
// Payload structs, field widths, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tba_pkg;

    // Field widths fixed by the payload format
    localparam int TIME_BITS      = 32;
    localparam int VALUE_BITS     = 24;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 1;

    localparam logic [TIME_BITS-1:0] BIN_WIDTH_RESET = TIME_BITS'(1000);

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_BIN_WIDTH   = 1'b0,
        REG_CUTOFF_TIME = 1'b1
    } tba_reg_idx_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  sample_time;
        logic [VALUE_BITS-1:0] sample_value;
    } tba_in_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  bin_time;
        logic [VALUE_BITS-1:0] bin_average;
    } tba_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic setup;    // close the bin, start the dividers
        logic finish;   // apply catch-up, load the result
    } tba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_bin;   // sample on the input falls in the open bin
        logic div_done; // both dividers idle
        logic emit;     // closed bin produces a result
    } tba_stat_t;

endpackage

`default_nettype wire

// ===== design/tba_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by the datapath for the bin mean and the catch-up remainder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tba_div #(
    parameter int DIVIDEND_BITS = 40,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          busy,
    output logic [DIVIDEND_BITS-1:0]      quotient,
    output logic [DIVISOR_BITS-1:0]       remainder
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  div_reg;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/tba_datapath.sv =====
// Datapath of the time-binned averager: config registers, bin state,
// the two serial dividers and the result register.
// Depends on tba_pkg and tba_div.
`timescale 1ns / 1ps
`default_nettype none

module tba_datapath
    import tba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire tba_in_t                  s_data,
    output tba_out_t                      m_data,
    input  wire tba_cmd_t                 cmd,
    output tba_stat_t                     stat
);

    localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;

    logic [TIME_BITS-1:0]  bin_width_reg;
    logic [TIME_BITS-1:0]  cutoff_reg;
    logic [TIME_BITS-1:0]  bin_start_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [TIME_BITS-1:0]  t_reg;
    logic [TIME_BITS-1:0]  diff_reg;
    logic [TIME_BITS-1:0]  t_minus_w_reg;
    logic                  emit_reg;
    tba_out_t              out_reg;

    logic [TIME_BITS-1:0]  w_eff;
    logic [TIME_BITS-1:0]  diff;
    logic                  in_bin;
    logic [TIME_BITS-1:0]  off;

    logic                  busy_a;
    logic                  busy_b;
    logic [SUM_BITS-1:0]   quo_a;
    logic [TIME_BITS-1:0]  quo_b;
    logic [TIME_BITS-1:0]  rem_b;
    logic                  catch_up;

    // A zero width behaves as a width of one
    assign w_eff = (bin_width_reg == '0) ? TIME_BITS'(1) : bin_width_reg;

    // Bin membership: before the start, or offset below the width
    assign diff   = s_data.sample_time - bin_start_reg;
    assign in_bin = (s_data.sample_time < bin_start_reg) || (diff < w_eff);

    // Offset past the advanced start; it never underflows on a close
    assign off = diff_reg - w_eff;

    // Two or more widths past: start lands at t - w - (off mod w)
    assign catch_up = |quo_b[TIME_BITS-1:1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_width_reg <= BIN_WIDTH_RESET;
            cutoff_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BIN_WIDTH:   bin_width_reg <= cfg_wdata[TIME_BITS-1:0];
                REG_CUTOFF_TIME: cutoff_reg    <= cfg_wdata[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Bin state: accumulate, clear on close, advance the start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_start_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end else if (cmd.accept && in_bin) begin
            if (count_reg != '1) begin
                sum_reg   <= sum_reg + SUM_BITS'(s_data.sample_value);
                count_reg <= count_reg + 1'b1;
            end
        end else if (cmd.setup) begin
            bin_start_reg <= bin_start_reg + w_eff;
            sum_reg       <= '0;
            count_reg     <= '0;
        end else if (cmd.finish && catch_up) begin
            bin_start_reg <= t_minus_w_reg - rem_b;
        end
    end

    // Closing sample and derived values
    always_ff @(posedge aclk) begin
        if (cmd.accept && !in_bin) begin
            t_reg    <= s_data.sample_time;
            diff_reg <= diff;
        end
        if (cmd.setup) begin
            t_minus_w_reg <= t_reg - w_eff;
            emit_reg      <= (t_reg > cutoff_reg) && (count_reg != '0);
        end
    end

    // Result register; bin_start still holds the first advance here
    always_ff @(posedge aclk) begin
        if (cmd.finish && emit_reg) begin
            out_reg.bin_time    <= bin_start_reg;
            out_reg.bin_average <= quo_a[VALUE_BITS-1:0];
        end
    end

    // Mean of the closed bin
    tba_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_div_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.setup),
        .dividend  (sum_reg),
        .divisor   (count_reg),
        .busy      (busy_a),
        .quotient  (quo_a),
        .remainder ()
    );

    // Skipped-bin count and leftover offset
    tba_div #(
        .DIVIDEND_BITS (TIME_BITS),
        .DIVISOR_BITS  (TIME_BITS)
    ) u_div_skip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.setup),
        .dividend  (off),
        .divisor   (w_eff),
        .busy      (busy_b),
        .quotient  (quo_b),
        .remainder (rem_b)
    );

    assign stat.in_bin   = in_bin;
    assign stat.div_done = !busy_a && !busy_b;
    assign stat.emit     = emit_reg;
    assign m_data        = out_reg;

endmodule

`default_nettype wire

// ===== design/tba_ctrl.sv =====
// Controller of the time-binned averager: sequences accept, bin close,
// division and result hand-off; owns both channel handshakes.
// Depends on tba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tba_ctrl
    import tba_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output tba_cmd_t       cmd,
    input  wire tba_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SETUP  = 3'b010,
        ST_DIVIDE = 3'b100
    } tba_state_t;

    tba_state_t state_reg;
    tba_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Commands
    always_comb begin
        cmd.accept = (state_reg == ST_IDLE) && s_valid;
        cmd.setup  = (state_reg == ST_SETUP);
        cmd.finish = (state_reg == ST_DIVIDE) && stat.div_done && (!stat.emit || out_free);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && !stat.in_bin) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        priority if (cmd.finish && stat.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // A new result only appears on leaving the divide state
    a_valid_from_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DIVIDE))
        else $error("result raised outside a bin close");

    // Setup always hands over to the dividers
    a_setup_to_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SETUP |=> state_reg == ST_DIVIDE)
        else $error("setup not followed by divide");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && stat.emit) |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    // No input request is taken while a bin close is in progress
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |=> !s_ready)
        else $error("input taken during bin close");

endmodule

`default_nettype wire

// ===== design/time_binned_average.sv =====
// Top level of the time-binned averager.
// Joins the controller and the datapath. Depends on tba_pkg, tba_ctrl, tba_datapath.
//
// Usage:
//   Input requests (s_valid/s_ready, s_data) carry a timestamp and a value.
//   A sample inside the open bin is added to the running sum on its accept,
//   so such samples can arrive back to back. A sample at or past the bin end
//   closes the bin: the block passes through a setup state, then the two bit-serial
//   dividers run in parallel (the mean over VALUE_BITS + COUNT_BITS = 40 bits, the
//   catch-up remainder over 32 bits), then a finish step loads the result. A closing
//   sample holds s_ready low until that finish, and its result, if any, is valid
//   after it; the 40-bit mean divider, the longer of the two, sets the wait.
//   Result requests (m_valid/m_ready, m_data) come from an output register;
//   the block keeps accepting in-bin samples while a result waits. If the
//   next bin close finds the result still untaken, it waits in its last
//   cycle until m_ready frees the register.
//   cfg_we/cfg_addr/cfg_wdata write bin_width (index 0) and cutoff_time
//   (index 1); write only while idle.
//   Reset (aresetn low, synchronous) clears the bin, sets bin_width to 1000
//   and cutoff_time to 0, and drops m_valid.
`timescale 1ns / 1ps
`default_nettype none

module time_binned_average
    import tba_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire tba_in_t                  s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output tba_out_t                      m_data,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    tba_cmd_t  cmd;
    tba_stat_t stat;

    tba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tba_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for time_binned_average: drives timestamped samples,
// predicts closed-bin means and start times, and compares every result.
// Depends on tba_pkg and the time_binned_average RTL.
`timescale 1ns / 1ps

module tb_top;
    import tba_pkg::*;

    localparam int SETTLE_CYCLES = 64;    // covers a bin close
    localparam int COUNT_W       = COUNT_BITS_DEF;
    localparam int SUM_W         = VALUE_BITS + COUNT_W;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    tba_in_t                  s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    tba_out_t                 m_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    time_binned_average dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Samples waiting to be sent, and bin results predicted but not yet seen
    tba_in_t  samples_to_send[$];
    tba_out_t bins_due[$];

    // Shadow of the block's registers and open bin
    logic [TIME_BITS-1:0]     width_reg  = BIN_WIDTH_RESET;
    logic [TIME_BITS-1:0]     cutoff_reg = '0;
    logic [TIME_BITS-1:0]     open_start = '0;
    logic [SUM_W-1:0]         open_sum   = '0;
    logic [COUNT_W-1:0]       open_count = '0;

    // Stimulus pacing
    longint unsigned stamp      = 0;
    int unsigned     send_odds  = 10;
    int unsigned     recv_odds  = 10;
    bit              quiet      = 1'b0;
    int unsigned     send_gap   = 0;
    int unsigned     recv_hold  = 0;
    int unsigned     mismatches = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic flag_mismatch(string what);
        if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Fold one accepted sample into the shadow bin; queue a result on emit
    function automatic void fold_sample(tba_in_t item);
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] w;
        logic [TIME_BITS-1:0] off;
        logic [TIME_BITS-1:0] skips;
        logic [SUM_W-1:0]     mean;
        tba_out_t             res;
        t = item.sample_time;
        w = (width_reg == '0) ? TIME_BITS'(1) : width_reg;
        if (t < open_start || (t - open_start) < w) begin
            // count saturates: later samples of the bin are dropped
            if (open_count != '1) begin
                open_sum   = open_sum + item.sample_value;
                open_count = open_count + 1'b1;
            end
            return;
        end
        open_start = open_start + w;
        if (t > cutoff_reg && open_count != '0) begin
            mean            = open_sum / {{(SUM_W-COUNT_W){1'b0}}, open_count};
            res.bin_time    = open_start;
            res.bin_average = mean[VALUE_BITS-1:0];
            bins_due.push_back(res);
        end
        open_sum   = '0;
        open_count = '0;
        // skip empty bins so the sample lands one to two widths past the start
        if (t >= open_start) begin
            off   = t - open_start;
            skips = off / w;
            if (skips >= 2) open_start = open_start + (skips - 1) * w;
        end
    endfunction

    task automatic check_bin(tba_out_t got);
        tba_out_t want;
        if (bins_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result bin_time=%0d bin_average=%06h",
                                    got.bin_time, got.bin_average));
            return;
        end
        want = bins_due.pop_front();
        if (got.bin_time !== want.bin_time) begin
            flag_mismatch($sformatf("bin_time got %0d want %0d",
                                    got.bin_time, want.bin_time));
        end
        if (got.bin_average !== want.bin_average) begin
            flag_mismatch($sformatf("bin_average got %06h want %06h (bin_time %0d)",
                                    got.bin_average, want.bin_average, want.bin_time));
        end
    endtask

    // Input driver: presents queued samples, with random idle bursts between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) fold_sample(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (samples_to_send.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= samples_to_send.pop_front();
                    if (!quiet && $urandom_range(99) < send_odds) begin
                        send_gap <= $urandom_range(10, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stall bursts on m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready) check_bin(m_data);
            if (recv_hold != 0) begin
                m_ready   <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else if (!quiet && $urandom_range(99) < recv_odds) begin
                m_ready   <= 1'b0;
                recv_hold <= $urandom_range(9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_sample(logic [TIME_BITS-1:0] t, logic [VALUE_BITS-1:0] v);
        tba_in_t item;
        item.sample_time  = t;
        item.sample_value = v;
        samples_to_send.push_back(item);
    endtask

    function automatic longint unsigned rand_upto(longint unsigned lim);
        if (lim >= 64'hFFFF_FFFF) return {32'd0, $urandom()};
        return {32'd0, $urandom_range(32'(lim))};
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom());
        endcase
    endfunction

    // Register write; only called while the block is idle
    task automatic write_reg(tba_reg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_BIN_WIDTH) width_reg = value;
        else cutoff_reg = value;
    endtask

    // Wait until every sample is taken and every result seen, then let a close finish
    task automatic drain_all();
        do @(negedge aclk);
        while (samples_to_send.size() != 0 || s_valid || bins_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly forward-moving time with in-bin steps, bin closes, multi-bin
    // skips, long jumps and the odd sample from the past
    task automatic random_phase(int count);
        longint unsigned      w;
        logic [TIME_BITS-1:0] t;
        int                   pick;
        @(negedge aclk);
        if (!quiet) begin
            send_odds = 10 * $urandom_range(3);
            recv_odds = 10 * $urandom_range(3);
        end
        w = (width_reg == '0) ? 1 : width_reg;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) stamp += rand_upto(w / 4);
            else if (pick < 75) stamp += w / 2 + rand_upto(w);
            else if (pick < 85) stamp += w * $urandom_range(12, 2) + rand_upto(w);
            else if (pick < 90) stamp += rand_upto(64'h0400_0000);
            if (stamp > 64'hFFFF_FFFF) stamp = 64'hFFFF_FFFF;
            t = (pick >= 90) ? TIME_BITS'(rand_upto(stamp)) : TIME_BITS'(stamp);
            queue_sample(t, rand_value());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset width 1000, cutoff 0
        @(negedge aclk);
        queue_sample(32'd0,    24'h000000);
        queue_sample(32'd10,   24'hFFFFFF);
        queue_sample(32'd999,  24'h000001);   // last tick of the first bin
        queue_sample(32'd1000, 24'h123456);   // closes on the exact boundary
        queue_sample(32'd500,  24'h000007);   // before the bin start, still added
        queue_sample(32'd1999, 24'h800000);
        queue_sample(32'd5500, 24'h0000FF);   // close plus catch-up over empty bins
        queue_sample(32'd5600, 24'hABCDEF);   // closes an empty bin: no result
        queue_sample(32'd5700, 24'h000100);
        drain_all();

        // Directed: closes at or under the cutoff stay silent
        write_reg(REG_CUTOFF_TIME, 32'd8000);
        @(negedge aclk);
        queue_sample(32'd6000, 24'h00FF00);
        queue_sample(32'd6500, 24'h0F0F0F);
        queue_sample(32'd8000, 24'hF0F0F0);   // time equal to the cutoff
        queue_sample(32'd8500, 24'h3C3C3C);
        queue_sample(32'd8600, 24'hC3C3C3);
        queue_sample(32'd9000, 24'h5A5A5A);   // first close past the cutoff that emits
        drain_all();
        write_reg(REG_CUTOFF_TIME, 32'd0);

        // Dense bin: a burst of mostly near full-scale samples at one timestamp
        @(negedge aclk);
        send_odds = 5;
        recv_odds = 5;
        for (int i = 0; i < 24; i++) begin
            queue_sample(32'd9500, (i < 20) ?
                         VALUE_BITS'($urandom_range(24'hFFFFFF, 24'hFFFF00)) : '0);
        end
        queue_sample(32'd10000, 24'h000042);
        stamp = 10000;
        drain_all();

        // Random phases over a range of widths and cutoffs
        write_reg(REG_BIN_WIDTH, 32'd1);
        random_phase(100);
        drain_all();
        write_reg(REG_BIN_WIDTH, 32'd0);       // zero width acts as one tick
        random_phase(100);
        drain_all();
        write_reg(REG_BIN_WIDTH, 32'd37);
        random_phase(100);
        drain_all();
        write_reg(REG_BIN_WIDTH, 32'd5000);
        write_reg(REG_CUTOFF_TIME, 32'(stamp + 30000));
        random_phase(110);
        drain_all();
        write_reg(REG_BIN_WIDTH, 32'd777);
        write_reg(REG_CUTOFF_TIME, '1);        // nothing can pass this cutoff
        random_phase(100);
        drain_all();
        write_reg(REG_BIN_WIDTH, 32'd250_000);
        write_reg(REG_CUTOFF_TIME, '0);
        random_phase(100);
        drain_all();

        // Closing stretch without idling; time climbs to the top of the range
        quiet     = 1'b1;
        send_odds = 0;
        recv_odds = 0;
        write_reg(REG_BIN_WIDTH, 32'h0100_0000);
        random_phase(120);
        drain_all();
        write_reg(REG_BIN_WIDTH, '1);
        random_phase(20);
        queue_sample('1, '1);
        queue_sample('1, '0);
        drain_all();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tba_pkg.sv
design/tba_div.sv
design/tba_datapath.sv
design/tba_ctrl.sv
design/time_binned_average.sv
verif/tb_top.sv
